### sv/chs_pkg.sv
// shared types and codes for the cuckoo hash table
// no dependencies
package chs_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic REG_MAX_ROUNDS = 1'b1;

	localparam logic [2:0] ST_ABSENT  = 3'd0;
	localparam logic [2:0] ST_FOUND   = 3'd1;
	localparam logic [2:0] ST_INSERT  = 3'd2;
	localparam logic [2:0] ST_PRESENT = 3'd3;
	localparam logic [2:0] ST_REMOVED = 3'd4;
	localparam logic [2:0] ST_RM_MISS = 3'd5;
	localparam logic [2:0] ST_FAILED  = 3'd6;

	localparam logic [1:0] TBL_NONE   = 2'd0;
	localparam logic [1:0] TBL_FIRST  = 2'd1;
	localparam logic [1:0] TBL_SECOND = 2'd2;

	localparam logic KIND_DJB2 = 1'b0;
	localparam logic KIND_SDBM = 1'b1;

	localparam logic [31:0] DJB2_SEED = 32'd5381;

	typedef struct packed {
		logic start;
		logic kind;
	} hash_req_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
	} entry_t;

endpackage

### sv/cuckoo_hash_table.sv
// two-way cuckoo hash table, top level: sequencer, config registers, result register
// depends on chs_pkg, chs_hash, chs_store
//
//  channel   signals                                   direction
//  input     in_valid/in_ready, command, key           into block
//  result    out_valid/out_ready, status, which_table,
//            slot, spill_key                           out of block
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data  into block
//
// each hashed probe runs start, one key byte per cycle up to the zero byte that ends the key,
// a bit-serial remainder over the 32 hash bits, the done step, a memory read and a check.
// lookup and remove take one or two probes, insert two more per eviction round, so up to
// 2 * max_rounds + 2 probes; a placed key is then re-read from its slots, first table first.
// after reset a clearing pass zeroes both tables, in_ready low. a result waiting on
// out_ready does not block the next item.
module cuckoo_hash_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  which_table,
	output logic [9:0]  slot,
	output logic [63:0] spill_key,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import chs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = $clog2(TABLE_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HSTART = 3'd2;
	localparam logic [2:0] S_HWAIT  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_CHECK  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	// what the current probe is for
	localparam logic [2:0] PH_FIND1 = 3'd0;
	localparam logic [2:0] PH_FIND2 = 3'd1;
	localparam logic [2:0] PH_INS1  = 3'd2;
	localparam logic [2:0] PH_INS2  = 3'd3;
	localparam logic [2:0] PH_REF1  = 3'd4;
	localparam logic [2:0] PH_REF2  = 3'd5;

	logic [2:0]    state_q, phase_q;
	logic [AW:0]   clr_q;
	logic [10:0]   table_size_q;
	logic [6:0]    max_rounds_q;
	logic [6:0]    round_q;
	logic [1:0]    cmd_q;
	logic [63:0]   key_q, cur_q;
	logic [AW-1:0] addr_q, idx1_q, idx2_q;
	logic          out_valid_q;
	logic [2:0]    res_status_q, status_q;
	logic [1:0]    res_which_q, which_q;
	logic [AW-1:0] res_slot_q;
	logic [9:0]    slot_q;
	logic [63:0]   res_spill_q, spill_q;

	logic [SW-1:0] eff_size;
	hash_req_t     hreq;
	logic          hdone;
	logic [AW-1:0] hidx;
	entry_t        rd1, rd2, ent, wdata;
	logic          we1, we2, hit, tbl2;
	logic [AW-1:0] waddr;
	logic          fin_find;
	logic [1:0]    fin_which;
	logic [6:0]    round_nx;

	// keep bytes up to the first zero byte and below KEY_BYTES
	function automatic logic [63:0] norm_key(input logic [63:0] k);
		logic [63:0] o;
		logic        run;
		o   = '0;
		run = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (i >= KEY_BYTES || k[8*i +: 8] == 8'd0) run = 1'b0;
			if (run) o[8*i +: 8] = k[8*i +: 8];
		end
		return o;
	endfunction

	// zero acts as one, oversize clamps to the table depth
	always_comb begin
		if (table_size_q == 11'd0) eff_size = SW'(1);
		else if (32'(table_size_q) > TABLE_DEPTH) eff_size = SW'(TABLE_DEPTH);
		else eff_size = SW'(table_size_q);
	end

	assign hreq.start = (state_q == S_HSTART);
	assign hreq.kind  = (phase_q == PH_FIND2 || phase_q == PH_INS2) ? KIND_SDBM : KIND_DJB2;

	chs_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
		.clk(clk), .arst_n(arst_n), .req(hreq), .key(cur_q),
		.modulus(eff_size), .done(hdone), .idx(hidx)
	);

	chs_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_first (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(addr_q), .rdata(rd1)
	);

	chs_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_second (
		.clk(clk), .we(we2), .waddr(waddr), .wdata(wdata), .raddr(addr_q), .rdata(rd2)
	);

	assign tbl2 = (phase_q == PH_FIND2 || phase_q == PH_INS2 || phase_q == PH_REF2);
	assign ent  = tbl2 ? rd2 : rd1;
	assign hit  = ent.valid && (ent.key == key_q);

	// outcome of the initial search
	assign fin_find  = (phase_q == PH_FIND1 && hit) || (phase_q == PH_FIND2);
	assign fin_which = !hit ? TBL_NONE : ((phase_q == PH_FIND1) ? TBL_FIRST : TBL_SECOND);
	assign round_nx  = round_q + 7'd1;

	// table write port: clearing pass, remove, and insert swaps
	always_comb begin
		we1   = 1'b0;
		we2   = 1'b0;
		waddr = addr_q;
		wdata = '{valid: 1'b1, key: cur_q};
		if (state_q == S_CLEAR) begin
			we1   = 1'b1;
			we2   = 1'b1;
			waddr = clr_q[AW-1:0];
			wdata = '0;
		end else if (state_q == S_CHECK) begin
			unique case (phase_q)
				PH_FIND1, PH_FIND2: begin
					// remove drops the valid flag of the matching entry
					wdata = '{valid: 1'b0, key: ent.key};
					if (cmd_q == CMD_REMOVE && hit) begin
						we1 = (phase_q == PH_FIND1);
						we2 = (phase_q == PH_FIND2);
					end
				end
				PH_INS1: we1 = 1'b1;
				PH_INS2: we2 = 1'b1;
				default: ;
			endcase
		end
	end

	// config registers, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= 11'd1024;
			max_rounds_q <= 7'd8;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TABLE_SIZE) table_size_q <= cfg_data;
			else max_rounds_q <= cfg_data[6:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			phase_q     <= PH_FIND1;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise a new result, or retire the one taken this cycle
			if (state_q == S_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(TABLE_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_FIND1;
						state_q <= S_HSTART;
					end
				end
				S_HSTART: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (hdone) state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					unique case (phase_q)
						PH_FIND1, PH_FIND2: begin
							if (!fin_find) begin
								phase_q <= PH_FIND2;
								state_q <= S_HSTART;
							end else if (cmd_q == CMD_INSERT && fin_which == TBL_NONE
									&& max_rounds_q != 7'd0) begin
								phase_q <= PH_INS1;
								state_q <= S_HSTART;
							end else begin
								state_q <= S_OUT;
							end
						end
						PH_INS1: begin
							if (!ent.valid) begin
								phase_q <= PH_REF1;
								state_q <= S_READ;
							end else begin
								phase_q <= PH_INS2;
								state_q <= S_HSTART;
							end
						end
						PH_INS2: begin
							if (!ent.valid) begin
								phase_q <= PH_REF1;
								state_q <= S_READ;
							end else if (round_nx == max_rounds_q) begin
								state_q <= S_OUT;
							end else begin
								phase_q <= PH_INS1;
								state_q <= S_HSTART;
							end
						end
						PH_REF1: begin
							if (hit) begin
								state_q <= S_OUT;
							end else begin
								phase_q <= PH_REF2;
								state_q <= S_READ;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= command;
				key_q   <= norm_key(key);
				cur_q   <= norm_key(key);
				round_q <= '0;
			end
			S_HWAIT: begin
				if (hdone) begin
					addr_q <= hidx;
					if (phase_q == PH_FIND1) idx1_q <= hidx;
					if (phase_q == PH_FIND2) idx2_q <= hidx;
				end
			end
			S_CHECK: begin
				unique case (phase_q)
					PH_FIND1, PH_FIND2: begin
						res_which_q <= fin_which;
						res_slot_q  <= (fin_which == TBL_NONE) ? '0 : addr_q;
						res_spill_q <= '0;
						if (cmd_q == CMD_INSERT) begin
							if (fin_which != TBL_NONE) begin
								res_status_q <= ST_PRESENT;
							end else begin
								// no rounds allowed: fail with the key itself
								res_status_q <= ST_FAILED;
								res_spill_q  <= cur_q;
							end
						end else if (cmd_q == CMD_REMOVE) begin
							res_status_q <= (fin_which != TBL_NONE) ? ST_REMOVED : ST_RM_MISS;
						end else begin
							res_status_q <= (fin_which != TBL_NONE) ? ST_FOUND : ST_ABSENT;
						end
					end
					PH_INS1: begin
						if (ent.valid) cur_q <= ent.key;
						addr_q <= idx1_q;
					end
					PH_INS2: begin
						round_q <= round_nx;
						addr_q  <= idx1_q;
						if (ent.valid) begin
							cur_q <= ent.key;
							// rounds used up: report the key still in hand
							res_status_q <= ST_FAILED;
							res_which_q  <= TBL_NONE;
							res_slot_q   <= '0;
							res_spill_q  <= ent.key;
						end
					end
					PH_REF1: begin
						addr_q       <= idx2_q;
						res_status_q <= ST_INSERT;
						res_which_q  <= TBL_FIRST;
						res_slot_q   <= addr_q;
						res_spill_q  <= '0;
					end
					default: begin
						res_status_q <= ST_INSERT;
						res_which_q  <= hit ? TBL_SECOND : TBL_NONE;
						res_slot_q   <= hit ? addr_q : '0;
						res_spill_q  <= '0;
					end
				endcase
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					status_q  <= res_status_q;
					which_q   <= res_which_q;
					slot_q    <= 10'(res_slot_q);
					spill_q   <= res_spill_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign which_table = which_q;
	assign slot        = slot_q;
	assign spill_key   = spill_q;

`ifndef SYNTHESIS
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FAILED) |-> (which_q == TBL_NONE && slot_q == 10'd0))
		else $error("failed insert carries a location");

	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hdone |-> (state_q == S_HWAIT))
		else $error("hash finished while the sequencer was not waiting");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input ready during the clearing pass");
`endif

endmodule

### sv/chs_hash.sv
// shared hash unit: one key byte per cycle, then a bit-serial remainder
// depends on chs_pkg
module chs_hash #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chs_pkg::hash_req_t req,
	input  logic [63:0]       key,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] modulus,
	output logic              done,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] idx
);
	import chs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = SW + 1;

	logic          busy_q, modp_q, kind_q, done_q;
	logic [63:0]   kbuf_q;
	logic [31:0]   h_q;
	logic [RW-1:0] r_q;
	logic [4:0]    bit_q;
	logic [AW-1:0] idx_q;

	logic [7:0]    c;
	logic [31:0]   h_djb, h_sdbm;
	logic [RW-1:0] rsh, rsub, mext;
	logic          ge;

	assign c      = kbuf_q[7:0];
	assign h_djb  = (h_q << 5) + h_q + {24'd0, c};
	assign h_sdbm = {24'd0, c} + (h_q << 6) + (h_q << 16) - h_q;
	assign mext   = {1'b0, modulus};
	assign rsh    = {r_q[RW-2:0], h_q[31]};
	assign ge     = (rsh >= mext);
	assign rsub   = rsh - mext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			modp_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				modp_q <= 1'b0;
				bit_q  <= '0;
			end else if (busy_q) begin
				if (!modp_q) begin
					if (c == 8'd0) modp_q <= 1'b1;
				end else begin
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd31) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			kind_q <= req.kind;
			kbuf_q <= key;
			h_q    <= (req.kind == KIND_SDBM) ? 32'd0 : DJB2_SEED;
			r_q    <= '0;
		end else if (busy_q) begin
			if (!modp_q) begin
				if (c != 8'd0) begin
					h_q    <= (kind_q == KIND_SDBM) ? h_sdbm : h_djb;
					kbuf_q <= kbuf_q >> 8;
				end
			end else begin
				r_q <= ge ? rsub : rsh;
				h_q <= h_q << 1;
				if (bit_q == 5'd31) idx_q <= AW'(ge ? rsub : rsh);
			end
		end
	end

	assign done = done_q;
	assign idx  = idx_q;

endmodule

### sv/chs_store.sv
// one table of key entries with a valid flag, one write and one registered read
// depends on chs_pkg
module chs_store #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            we,
	input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
	input  chs_pkg::entry_t wdata,
	input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
	output chs_pkg::entry_t rdata
);
	import chs_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### bench/cuckoo_hash_table_test.sv
// self-checking bench for the two-way cuckoo hash table
// depends on chs_pkg and the cuckoo_hash_table rtl
`timescale 1ns / 100ps

module cuckoo_hash_table_test;
	import chs_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int CYCLE_LIMIT = 40000000;
	localparam int DIRECTED_N  = 14;

	typedef struct {
		logic [2:0]  status;
		logic [1:0]  which_table;
		logic [9:0]  slot;
		logic [63:0] spill_key;
	} answer_t;

	typedef struct {
		logic [1:0]  command;
		logic [63:0] key;
		bit          typed;
		answer_t     answer;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [63:0] key;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [1:0]  which_table;
	logic [9:0]  slot;
	logic [63:0] spill_key;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [10:0] cfg_data;

	cuckoo_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .key(key),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.which_table(which_table), .slot(slot), .spill_key(spill_key),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of both tables and the two registers
	logic [63:0] shadow_first_keys [DEPTH];
	logic        shadow_first_valid [DEPTH];
	logic [63:0] shadow_second_keys [DEPTH];
	logic        shadow_second_valid [DEPTH];
	logic [10:0] shadow_size;
	logic [6:0]  shadow_rounds;

	answer_t pending_answers [$];
	int      mismatches;
	int      cycles;
	bit      quiet_tail;    // no idling on either side near the end

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic logic [31:0] modulus();
		if (shadow_size == 0) return 32'd1;
		if (shadow_size > DEPTH) return 32'(DEPTH);
		return 32'(shadow_size);
	endfunction

	// clear everything from the first zero byte upward
	function automatic logic [63:0] trim_key(logic [63:0] raw);
		logic [63:0] k;
		bit          stop;
		k = '0;
		stop = 0;
		for (int i = 0; i < 8; i++) begin
			if (raw[8*i +: 8] == 8'd0) stop = 1;
			if (!stop) k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	function automatic logic [9:0] bucket(logic [63:0] k, logic kind);
		logic [31:0] h;
		logic [31:0] c;
		bit          stop;
		h = (kind == KIND_SDBM) ? 32'd0 : DJB2_SEED;
		stop = 0;
		for (int i = 0; i < 8; i++) begin
			c = {24'd0, k[8*i +: 8]};
			if (c == 0) stop = 1;
			if (!stop) begin
				if (kind == KIND_SDBM) h = c + (h << 6) + (h << 16) - h;
				else h = (h << 5) + h + c;
			end
		end
		return 10'(h % modulus());
	endfunction

	// table one first, then table two
	function automatic logic [1:0] locate(logic [63:0] k, output logic [9:0] where);
		logic [9:0] i;
		i = bucket(k, KIND_DJB2);
		if (shadow_first_valid[i] && shadow_first_keys[i] == k) begin
			where = i;
			return TBL_FIRST;
		end
		i = bucket(k, KIND_SDBM);
		if (shadow_second_valid[i] && shadow_second_keys[i] == k) begin
			where = i;
			return TBL_SECOND;
		end
		where = '0;
		return TBL_NONE;
	endfunction

	function automatic answer_t apply_command(logic [1:0] cmd, logic [63:0] raw);
		answer_t     a;
		logic [63:0] k;
		logic [63:0] in_hand;
		logic [63:0] tmp;
		logic [9:0]  i;
		bit          placed;
		k = trim_key(raw);
		a.spill_key = '0;
		a.which_table = locate(k, a.slot);
		if (cmd == CMD_INSERT) begin
			if (a.which_table != TBL_NONE) begin
				a.status = ST_PRESENT;
			end else begin
				in_hand = k;
				placed = 0;
				for (int r = 0; r < shadow_rounds && !placed; r++) begin
					i = bucket(in_hand, KIND_DJB2);
					if (!shadow_first_valid[i]) begin
						shadow_first_valid[i] = 1;
						shadow_first_keys[i] = in_hand;
						placed = 1;
					end else begin
						tmp = shadow_first_keys[i];
						shadow_first_keys[i] = in_hand;
						in_hand = tmp;
						i = bucket(in_hand, KIND_SDBM);
						if (!shadow_second_valid[i]) begin
							shadow_second_valid[i] = 1;
							shadow_second_keys[i] = in_hand;
							placed = 1;
						end else begin
							tmp = shadow_second_keys[i];
							shadow_second_keys[i] = in_hand;
							in_hand = tmp;
						end
					end
				end
				if (placed) begin
					a.status = ST_INSERT;
					a.which_table = locate(k, a.slot);
				end else begin
					a.status = ST_FAILED;
					a.which_table = TBL_NONE;
					a.slot = '0;
					a.spill_key = in_hand;
				end
			end
		end else if (cmd == CMD_REMOVE) begin
			if (a.which_table == TBL_FIRST) begin
				shadow_first_valid[a.slot] = 0;
				a.status = ST_REMOVED;
			end else if (a.which_table == TBL_SECOND) begin
				shadow_second_valid[a.slot] = 0;
				a.status = ST_REMOVED;
			end else begin
				a.status = ST_RM_MISS;
			end
		end else begin
			// command 3 behaves as a lookup
			a.status = (a.which_table != TBL_NONE) ? ST_FOUND : ST_ABSENT;
		end
		return a;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------
	task automatic idle_gap();
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// one input transaction; the typed answer, when given, replaces the prediction
	task automatic send_item(logic [1:0] cmd, logic [63:0] raw, bit typed, answer_t fixed);
		answer_t a;
		in_valid <= 1'b1;
		command  <= cmd;
		key      <= raw;
		do @(posedge clk); while (!in_ready);
		a = apply_command(cmd, raw);
		pending_answers.push_back(typed ? fixed : a);
		idle_gap();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		// a result is the last thing an item does, so only a short settle is needed
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TABLE_SIZE) shadow_size = value;
		else shadow_rounds = value[6:0];
		@(posedge clk);
	endtask

	// a fully random key, or a fresh one with random length and trailing garbage
	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		int          len;
		k = {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0) return k;
		len = $urandom_range(0, 8);
		for (int i = 0; i < 8; i++) begin
			if (i < len) k[8*i +: 8] = 8'($urandom_range(1, 255));
			else if (i == len) k[8*i +: 8] = 8'd0;
		end
		return k;
	endfunction

	task automatic random_phase(int items, int pool_size);
		logic [63:0] pool [$];
		logic [63:0] k;
		logic [1:0]  cmd;
		int          pick;
		answer_t     none;
		none = '{default: '0};
		for (int i = 0; i < pool_size; i++) pool.push_back(fresh_key());
		for (int n = 0; n < items; n++) begin
			k = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, pool_size - 1)]
				: fresh_key();
			pick = $urandom_range(0, 99);
			if (pick < 45) cmd = CMD_INSERT;
			else if (pick < 70) cmd = CMD_LOOKUP;
			else if (pick < 94) cmd = CMD_REMOVE;
			else cmd = CMD_SPARE;
			send_item(cmd, k, 0, none);
		end
	endtask

	// ---------------------------------------------------------------
	// result checker and receiver stalls
	// ---------------------------------------------------------------
	int stall_left;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: status %0d", status);
				end else begin
					answer_t e;
					e = pending_answers.pop_front();
					if (status !== e.status || which_table !== e.which_table ||
						slot !== e.slot || spill_key !== e.spill_key) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp st %0d tbl %0d slot %0d spill %h,",
								" got st %0d tbl %0d slot %0d spill %h"},
								e.status, e.which_table, e.slot, e.spill_key,
								status, which_table, slot, spill_key);
					end
				end
			end
			// stall the receiver in bursts, stall_left counting down the rest of a burst
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cuckoo_hash_table_test: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	stim_row_t plan [DIRECTED_N];

	initial begin
		answer_t none;
		none = '{default: '0};
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_LOOKUP;
		key = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TABLE_SIZE;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		stall_left = 0;
		quiet_tail = 0;
		shadow_size = 11'd1024;
		shadow_rounds = 7'd8;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_first_keys[i] = '0;
			shadow_first_valid[i] = 0;
			shadow_second_keys[i] = '0;
			shadow_second_valid[i] = 0;
		end

		// directed rows: typed answers on an empty table, the rest predicted
		plan[0]  = '{CMD_LOOKUP, 64'h0, 1, '{ST_ABSENT, TBL_NONE, 10'd0, 64'h0}};
		plan[1]  = '{CMD_REMOVE, 64'h0, 1, '{ST_RM_MISS, TBL_NONE, 10'd0, 64'h0}};
		plan[2]  = '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1,
			'{ST_ABSENT, TBL_NONE, 10'd0, 64'h0}};
		plan[3]  = '{CMD_INSERT, 64'h0, 0, none};               // empty key
		plan[4]  = '{CMD_LOOKUP, 64'hDEAD_BEEF_0000_0000, 0, none}; // also the empty key
		plan[5]  = '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, none};
		plan[6]  = '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, none}; // already present
		plan[7]  = '{CMD_INSERT, 64'hFFFF_FFFF_FF00_FF41, 0, none}; // garbage past end
		plan[8]  = '{CMD_SPARE,  64'h0000_0000_0000_0041, 0, none}; // unknown command
		plan[9]  = '{CMD_INSERT, 64'h0101_0101_0101_0101, 0, none};
		plan[10] = '{CMD_REMOVE, 64'h0000_0000_0000_0041, 0, none};
		plan[11] = '{CMD_REMOVE, 64'h0000_0000_0000_0041, 0, none};
		plan[12] = '{CMD_LOOKUP, 64'h0101_0101_0101_0101, 0, none};
		plan[13] = '{CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 0, none};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_N; r++)
			send_item(plan[r].command, plan[r].key, plan[r].typed, plan[r].answer);

		// sender holds off until the block has answered everything
		drain();

		random_phase(130, 60);
		drain();
		write_reg(REG_TABLE_SIZE, 11'd1);          // one slot per table
		write_reg(REG_MAX_ROUNDS, 11'd1);
		random_phase(60, 6);
		drain();
		write_reg(REG_TABLE_SIZE, 11'd0);          // zero acts as one
		write_reg(REG_MAX_ROUNDS, 11'd0);          // every insert of an absent key fails
		random_phase(50, 6);
		drain();
		write_reg(REG_TABLE_SIZE, 11'd16);
		write_reg(REG_MAX_ROUNDS, 11'd64);
		random_phase(90, 40);
		drain();
		write_reg(REG_TABLE_SIZE, 11'd2047);       // above depth acts as depth
		write_reg(REG_MAX_ROUNDS, 11'd3);
		random_phase(120, 80);
		drain();
		write_reg(REG_TABLE_SIZE, 11'd1024);
		write_reg(REG_MAX_ROUNDS, 11'd64);
		quiet_tail = 1;
		random_phase(236, 60);
		drain();

		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("cuckoo_hash_table_test: done, clean");
		else
			$display("cuckoo_hash_table_test: done, errors");
		$finish;
	end

endmodule
